>>> rtl/ktt_pkg.sv
// shared types and constants for the keyed tag table with round-robin eviction
// depends on nothing; used by ktt_store, keyed_tag_table_rr_evict and the testbench
package ktt_pkg;

    // table geometry
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    // field widths of a beat
    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 16;
    localparam int OWNER_W  = 22;
    localparam int TAG_W    = 5;
    localparam int SLOT_W   = 6;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2
    } state_t;

    // one table slot
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    // slot write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } wr_req_t;

    // slot clear request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } clr_req_t;

endpackage

>>> rtl/keyed_tag_table_rr_evict.sv
// top level of the keyed tag table: command sequencer, scan and round-robin eviction
// depends on ktt_pkg and ktt_store
//
// Every command (insert, lookup, clear, or the unused code) walks all ENTRIES slots
// through the single read port of the slot memory, one slot per cycle, then writes
// back. A command accepted at an edge (start high, busy low) raises its result
// strobe done as the sequencer returns to idle, and busy drops in that same cycle;
// a new command is only taken after the last one is done. The result is shown on
// done for exactly one cycle; the receiver must take it then. Reset empties the
// whole table at once via per-slot valid bits, so no clearing pass is needed and
// the first command may start right after reset.
module keyed_tag_table_rr_evict
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ktt_pkg::CMD_W-1:0]    command,
    input  logic [ktt_pkg::HANDLE_W-1:0] file_handle,
    input  logic [ktt_pkg::OWNER_W-1:0]  process_id,
    input  logic [ktt_pkg::TAG_W-1:0]    tag_in,
    output logic                         done,
    output logic [ktt_pkg::TAG_W-1:0]    tag_out,
    output logic                         hit,
    output logic [ktt_pkg::SLOT_W-1:0]   slot_index,
    output logic                         evicted
);

    ktt_pkg::state_t                state_reg, state_next;
    logic [ktt_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           cmp_pend_reg, cmp_pend_next;
    logic [ktt_pkg::IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    ktt_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [ktt_pkg::HANDLE_W-1:0]   handle_reg, handle_next;
    logic [ktt_pkg::OWNER_W-1:0]    owner_reg, owner_next;
    logic [ktt_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic                           found_reg, found_next;
    logic [ktt_pkg::IDX_W-1:0]      match_idx_reg, match_idx_next;
    logic [ktt_pkg::TAG_W-1:0]      match_tag_reg, match_tag_next;
    logic                           empty_found_reg, empty_found_next;
    logic [ktt_pkg::IDX_W-1:0]      empty_idx_reg, empty_idx_next;
    logic [ktt_pkg::IDX_W-1:0]      ptr_reg, ptr_next;
    logic                           done_reg, done_next;
    logic [ktt_pkg::TAG_W-1:0]      tag_out_reg, tag_out_next;
    logic                           hit_reg, hit_next;
    logic [ktt_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic                           evicted_reg, evicted_next;

    logic                           rd_en;
    logic [ktt_pkg::IDX_W-1:0]      rd_idx;
    ktt_pkg::entry_t                rd_entry;
    ktt_pkg::wr_req_t               wr;
    ktt_pkg::clr_req_t              clr;
    logic                           key_match;
    logic                           slot_empty;
    logic                           scan_last;
    logic [ktt_pkg::IDX_W-1:0]      ins_idx;

    // slot memory
    ktt_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr       (wr),
        .clr      (clr)
    );

    // compare stage on the returning read beat
    assign key_match  = (rd_entry.handle == handle_reg) && (rd_entry.owner == owner_reg);
    assign slot_empty = (rd_entry.handle == '0);
    assign scan_last  = cmp_pend_reg
                        && (cmp_idx_reg == ktt_pkg::IDX_W'(ktt_pkg::ENTRIES - 1));

    // insert target: matching slot, else first empty, else round-robin victim
    always_comb
    begin
        if (found_reg)
        begin
            ins_idx = match_idx_reg;
        end
        else if (empty_found_reg)
        begin
            ins_idx = empty_idx_reg;
        end
        else
        begin
            ins_idx = ptr_reg;
        end
    end

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ktt_pkg::ST_IDLE;
            cnt_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            ptr_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cmp_pend_reg <= cmp_pend_next;
            ptr_reg      <= ptr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        cmd_reg         <= cmd_next;
        handle_reg      <= handle_next;
        owner_reg       <= owner_next;
        tag_reg         <= tag_next;
        found_reg       <= found_next;
        match_idx_reg   <= match_idx_next;
        match_tag_reg   <= match_tag_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        tag_out_reg     <= tag_out_next;
        hit_reg         <= hit_next;
        slot_reg        <= slot_next;
        evicted_reg     <= evicted_next;
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmp_pend_next    = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        cmd_next         = cmd_reg;
        handle_next      = handle_reg;
        owner_next       = owner_reg;
        tag_next         = tag_reg;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_tag_next   = match_tag_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        ptr_next         = ptr_reg;
        done_next        = 1'b0;
        tag_out_next     = tag_out_reg;
        hit_next         = hit_reg;
        slot_next        = slot_reg;
        evicted_next     = evicted_reg;
        rd_en            = 1'b0;
        rd_idx           = cnt_reg[ktt_pkg::IDX_W-1:0];
        wr               = '0;
        clr              = '0;

        unique case (state_reg)
            ktt_pkg::ST_IDLE:
            begin
                // take a command beat
                if (start)
                begin
                    state_next       = ktt_pkg::ST_SCAN;
                    cnt_next         = '0;
                    cmd_next         = ktt_pkg::cmd_t'(command);
                    handle_next      = file_handle;
                    owner_next       = process_id;
                    tag_next         = tag_in;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                end
            end

            ktt_pkg::ST_SCAN:
            begin
                // issue one slot read per cycle
                if (cnt_reg < ktt_pkg::CNT_W'(ktt_pkg::ENTRIES))
                begin
                    rd_en         = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = cnt_reg[ktt_pkg::IDX_W-1:0];
                end

                // record first match and first empty slot
                if (cmp_pend_reg)
                begin
                    if (key_match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        match_idx_next = cmp_idx_reg;
                        match_tag_next = rd_entry.tag;
                    end
                    if (slot_empty && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = cmp_idx_reg;
                    end
                    // clear drops every matching slot as it streams past
                    if (key_match && (cmd_reg == ktt_pkg::CMD_CLEAR))
                    begin
                        clr.en  = 1'b1;
                        clr.idx = cmp_idx_reg;
                    end
                end

                if (scan_last)
                begin
                    state_next = ktt_pkg::ST_WRITE;
                end
            end

            ktt_pkg::ST_WRITE:
            begin
                // writeback and result beat
                state_next   = ktt_pkg::ST_IDLE;
                done_next    = 1'b1;
                tag_out_next = '0;
                hit_next     = 1'b0;
                slot_next    = '0;
                evicted_next = 1'b0;
                case (cmd_reg)
                    ktt_pkg::CMD_INSERT:
                    begin
                        hit_next         = found_reg;
                        slot_next        = ktt_pkg::SLOT_W'(ins_idx);
                        wr.en            = 1'b1;
                        wr.idx           = ins_idx;
                        wr.data.handle   = handle_reg;
                        wr.data.owner    = owner_reg;
                        wr.data.tag      = tag_reg;
                        if (!found_reg && !empty_found_reg)
                        begin
                            evicted_next = 1'b1;
                            ptr_next     = (ptr_reg == ktt_pkg::IDX_W'(ktt_pkg::ENTRIES - 1))
                                           ? '0 : ptr_reg + 1'b1;
                        end
                    end
                    ktt_pkg::CMD_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            hit_next     = 1'b1;
                            slot_next    = ktt_pkg::SLOT_W'(match_idx_reg);
                            tag_out_next = match_tag_reg;
                        end
                    end
                    ktt_pkg::CMD_CLEAR:
                    begin
                        if (found_reg)
                        begin
                            hit_next  = 1'b1;
                            slot_next = ktt_pkg::SLOT_W'(match_idx_reg);
                        end
                    end
                    default:
                    begin
                        hit_next = 1'b0;
                    end
                endcase
            end

            default:
            begin
                state_next = ktt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ktt_pkg::ST_IDLE);
    assign done       = done_reg;
    assign tag_out    = tag_out_reg;
    assign hit        = hit_reg;
    assign slot_index = slot_reg;
    assign evicted    = evicted_reg;

    // result beat only appears once the sequencer is back at idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // an accepted command keeps the block busy for the scan
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not start a scan");

    // eviction only on an insert that found no match
    assert property (@(posedge clk) disable iff (!rst_n) (done && evicted) |-> !hit)
        else $error("eviction reported together with a hit");

    // a nonzero tag is only reported on a hit
    assert property (@(posedge clk) disable iff (!rst_n) (done && (tag_out != '0)) |-> hit)
        else $error("tag reported without a hit");

    // pointer only moves on an eviction writeback
    assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg != $past(ptr_reg)) |-> (done && evicted))
        else $error("round-robin pointer moved without eviction");

endmodule

>>> rtl/ktt_store.sv
// slot memory with per-slot valid bits; an invalid slot reads as all zero
// depends on ktt_pkg
module ktt_store
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [ktt_pkg::IDX_W-1:0] rd_idx,
    output ktt_pkg::entry_t           rd_entry,
    input  ktt_pkg::wr_req_t          wr,
    input  ktt_pkg::clr_req_t         clr
);

    ktt_pkg::entry_t                mem [ktt_pkg::ENTRIES];
    logic [ktt_pkg::ENTRIES-1:0]    valid_reg;
    ktt_pkg::entry_t                rd_data_reg;
    logic                           rd_vld_reg;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    // synchronous read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // valid flag travels with the read beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_vld_reg <= valid_reg[rd_idx];
        end
    end

    // valid bits: reset empties the table, clear drops a slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (clr.en)
            begin
                valid_reg[clr.idx] <= 1'b0;
            end
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

    // write and clear never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(wr.en && clr.en))
        else $error("slot write and clear in the same cycle");

    // a written slot is valid afterwards
    assert property (@(posedge clk) disable iff (!rst_n) wr.en |=> valid_reg[$past(wr.idx)])
        else $error("written slot not marked valid");

    // a cleared slot is invalid afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (clr.en && !wr.en) |=> !valid_reg[$past(clr.idx)])
        else $error("cleared slot still valid");

endmodule

>>> sim/tb_keyed_tag_table_rr_evict.sv
// self-checking testbench for keyed_tag_table_rr_evict: directed table plus random traffic
// depends on ktt_pkg and the rtl top level; predicts beats from its table copy or a fixed row
module tb_keyed_tag_table_rr_evict;
    import ktt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_MAX    = 128;
    localparam int DIR_N       = 19;

    // one result beat as seen on the output ports
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } tag_result_t;

    // one row of the directed stimulus table
    typedef struct {
        cmd_t                op;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic [TAG_W-1:0]    tag;
        bit                  fixed;
        tag_result_t         res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] file_handle;
    logic [OWNER_W-1:0]  process_id;
    logic [TAG_W-1:0]    tag_in;
    logic                done;
    logic [TAG_W-1:0]    tag_out;
    logic                hit;
    logic [SLOT_W-1:0]   slot_index;
    logic                evicted;

    // predictor copy of the slot table
    logic [HANDLE_W-1:0] shadow_handle [ENTRIES];
    logic [OWNER_W-1:0]  shadow_owner  [ENTRIES];
    logic [TAG_W-1:0]    shadow_tag    [ENTRIES];
    int                  shadow_rr_ptr;

    tag_result_t         pending_results[$];
    bit                  row_fixed;
    tag_result_t         row_expect;
    int                  error_count;
    int                  cycle_count;
    int                  burst_left;

    // key pool used to make random traffic hit the table
    logic [HANDLE_W-1:0] pool_handle [POOL_MAX];
    logic [OWNER_W-1:0]  pool_owner  [POOL_MAX];
    int                  pool_n;

    dir_row_t            dir_rows [DIR_N];

    keyed_tag_table_rr_evict u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .file_handle (file_handle),
        .process_id  (process_id),
        .tag_in      (tag_in),
        .done        (done),
        .tag_out     (tag_out),
        .hit         (hit),
        .slot_index  (slot_index),
        .evicted     (evicted)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_error(input string msg);
        $display("[%0d] MISMATCH %s", cycle_count, msg);
        error_count++;
    endtask

    // apply one command to the shadow table and return the beat it should produce
    task automatic table_apply(input cmd_t op, input logic [HANDLE_W-1:0] h,
                               input logic [OWNER_W-1:0] o, input logic [TAG_W-1:0] t,
                               output tag_result_t r);
        int match_idx;
        int empty_idx;
        int s;
        match_idx = -1;
        empty_idx = -1;
        s = 0;
        r = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_idx < 0 && shadow_handle[i] == h && shadow_owner[i] == o)
                match_idx = i;
            if (empty_idx < 0 && shadow_handle[i] == '0)
                empty_idx = i;
        end
        case (op)
            CMD_INSERT:
            begin
                if (match_idx >= 0)
                begin
                    r.hit = 1'b1;
                    s = match_idx;
                end
                else if (empty_idx >= 0)
                    s = empty_idx;
                else
                begin
                    // full table: take the slot under the round-robin pointer
                    s = shadow_rr_ptr;
                    shadow_rr_ptr = (s + 1) % ENTRIES;
                    r.evicted = 1'b1;
                end
                shadow_handle[s] = h;
                shadow_owner[s]  = o;
                shadow_tag[s]    = t;
                r.slot = SLOT_W'(s);
            end
            CMD_LOOKUP:
            begin
                if (match_idx >= 0)
                begin
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(match_idx);
                    r.tag  = shadow_tag[match_idx];
                end
            end
            CMD_CLEAR:
            begin
                if (match_idx >= 0)
                begin
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(match_idx);
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (shadow_handle[i] == h && shadow_owner[i] == o)
                        begin
                            shadow_handle[i] = '0;
                            shadow_owner[i]  = '0;
                            shadow_tag[i]    = '0;
                        end
                    end
                end
            end
            default:
            begin
                // unused code leaves the table alone and returns all zero
            end
        endcase
    endtask

    // result check, then prediction for a beat accepted at this edge
    always @(posedge clk)
    begin
        tag_result_t got_r;
        tag_result_t exp_r;
        tag_result_t pred_r;
        if (rst_n)
        begin
            if (done)
            begin
                got_r = '{tag_out, hit, slot_index, evicted};
                if (pending_results.size() == 0)
                    report_error($sformatf("result beat with nothing pending: %p", got_r));
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got_r.tag !== exp_r.tag)
                        report_error($sformatf("tag_out exp %0d got %0d",
                                               exp_r.tag, got_r.tag));
                    if (got_r.hit !== exp_r.hit)
                        report_error($sformatf("hit exp %0d got %0d",
                                               exp_r.hit, got_r.hit));
                    if (got_r.slot !== exp_r.slot)
                        report_error($sformatf("slot_index exp %0d got %0d",
                                               exp_r.slot, got_r.slot));
                    if (got_r.evicted !== exp_r.evicted)
                        report_error($sformatf("evicted exp %0d got %0d",
                                               exp_r.evicted, got_r.evicted));
                end
            end
            if (start && !busy)
            begin
                table_apply(cmd_t'(command), file_handle, process_id, tag_in, pred_r);
                pending_results.push_back(row_fixed ? row_expect : pred_r);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_keyed_tag_table_rr_evict: done, errors");
            $finish;
        end
    end

    // present one command beat and hold it until the block takes it
    task automatic issue_beat(input cmd_t op, input logic [HANDLE_W-1:0] h,
                              input logic [OWNER_W-1:0] o, input logic [TAG_W-1:0] t,
                              input bit fixed, input tag_result_t res);
        @(negedge clk);
        command     = op;
        file_handle = h;
        process_id  = o;
        tag_in      = t;
        row_fixed   = fixed;
        row_expect  = res;
        start       = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // sender bursts: random gap before each burst, some long gap-free stretches
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
        end
        burst_left--;
    endtask

    // fill the key pool: nonzero handles only, with a few extremes
    task automatic build_key_pool(input int n);
        pool_n = n;
        for (int k = 0; k < n; k++)
        begin
            pool_handle[k] = HANDLE_W'($urandom_range(1, 65535));
            pool_owner[k]  = OWNER_W'($urandom);
            case ($urandom_range(0, 15))
                0: begin pool_handle[k] = '1; pool_owner[k] = '1; end
                1: pool_owner[k] = '0;
                default: ;
            endcase
        end
    endtask

    // one random beat: mostly pool keys, some noise, some zero-handle keys
    task automatic random_beat();
        int                  sel;
        int                  k;
        cmd_t                op;
        logic [HANDLE_W-1:0] h;
        logic [OWNER_W-1:0]  o;
        logic [TAG_W-1:0]    t;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, pool_n - 1);
        h   = pool_handle[k];
        o   = pool_owner[k];
        t   = TAG_W'($urandom);
        if (sel < 45)
            op = CMD_INSERT;
        else if (sel < 85)
        begin
            op = (sel < 70) ? CMD_LOOKUP : CMD_CLEAR;
            if ($urandom_range(0, 4) == 0)
            begin
                h = HANDLE_W'($urandom);
                o = OWNER_W'($urandom);
            end
        end
        else if (sel < 92)
        begin
            op = CMD_NONE;
            h  = HANDLE_W'($urandom);
            o  = OWNER_W'($urandom);
        end
        else
        begin
            op = cmd_t'($urandom_range(0, 2));
            h  = '0;
            if ($urandom_range(0, 1) == 0)
                o = '0;
        end
        pace();
        issue_beat(op, h, o, t, 1'b0, '0);
    endtask

    // stop sending until every pending result beat has come back
    task automatic drain_pending();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_NONE;
        file_handle = '0;
        process_id  = '0;
        tag_in      = '0;
        row_fixed   = 1'b0;
        row_expect  = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        pool_n      = 1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_handle[i] = '0;
            shadow_owner[i]  = '0;
            shadow_tag[i]    = '0;
        end
        shadow_rr_ptr = 0;

        // directed rows: fresh-table zero key, unused code, extremes, zero-handle insert
        dir_rows = '{
            '{CMD_LOOKUP, 16'h0000, 22'h000000, 5'd0,  1'b1, '{5'd0,  1'b1, 6'd0, 1'b0}},
            '{CMD_NONE,   16'hFFFF, 22'h3FFFFF, 5'd31, 1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_LOOKUP, 16'hFFFF, 22'h3FFFFF, 5'd0,  1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_INSERT, 16'hFFFF, 22'h3FFFFF, 5'd31, 1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_LOOKUP, 16'hFFFF, 22'h3FFFFF, 5'd0,  1'b1, '{5'd31, 1'b1, 6'd0, 1'b0}},
            '{CMD_INSERT, 16'hFFFF, 22'h3FFFFF, 5'd0,  1'b1, '{5'd0,  1'b1, 6'd0, 1'b0}},
            '{CMD_INSERT, 16'h0001, 22'h000000, 5'd5,  1'b1, '{5'd0,  1'b0, 6'd1, 1'b0}},
            '{CMD_INSERT, 16'h0000, 22'h155555, 5'd10, 1'b1, '{5'd0,  1'b0, 6'd2, 1'b0}},
            '{CMD_LOOKUP, 16'h0000, 22'h155555, 5'd0,  1'b1, '{5'd10, 1'b1, 6'd2, 1'b0}},
            '{CMD_INSERT, 16'h0002, 22'h000002, 5'd1,  1'b1, '{5'd0,  1'b0, 6'd2, 1'b0}},
            '{CMD_LOOKUP, 16'h0000, 22'h000000, 5'd0,  1'b1, '{5'd0,  1'b1, 6'd3, 1'b0}},
            '{CMD_INSERT, 16'h1234, 22'h0ABCDE, 5'd7,  1'b0, '0},
            '{CMD_CLEAR,  16'hFFFF, 22'h3FFFFF, 5'd0,  1'b1, '{5'd0,  1'b1, 6'd0, 1'b0}},
            '{CMD_LOOKUP, 16'hFFFF, 22'h3FFFFF, 5'd0,  1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_CLEAR,  16'hAAAA, 22'h2AAAAA, 5'd21, 1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_INSERT, 16'h0003, 22'h000001, 5'd9,  1'b1, '{5'd0,  1'b0, 6'd0, 1'b0}},
            '{CMD_CLEAR,  16'h0000, 22'h000000, 5'd0,  1'b0, '0},
            '{CMD_LOOKUP, 16'h0001, 22'h000000, 5'd0,  1'b1, '{5'd5,  1'b1, 6'd1, 1'b0}},
            '{CMD_LOOKUP, 16'h1234, 22'h0ABCDE, 5'd0,  1'b0, '0}
        };

        // reset once
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        for (int r = 0; r < DIR_N; r++)
        begin
            pace();
            issue_beat(dir_rows[r].op, dir_rows[r].handle, dir_rows[r].owner,
                       dir_rows[r].tag, dir_rows[r].fixed, dir_rows[r].res);
        end
        drain_pending();

        // wide pool: fill past capacity so round-robin eviction runs, then mixed traffic
        build_key_pool(POOL_MAX);
        for (int k = 0; k < 70; k++)
        begin
            pace();
            issue_beat(CMD_INSERT, pool_handle[k], pool_owner[k], TAG_W'($urandom),
                       1'b0, '0);
        end
        repeat (160) random_beat();
        drain_pending();

        // narrow pool: dense hits, reinserts and clears of the same few keys
        build_key_pool(6);
        repeat (110) random_beat();

        // wide pool again over a table already in use
        build_key_pool(POOL_MAX);
        for (int k = 0; k < 40; k++)
        begin
            pace();
            issue_beat(CMD_INSERT, pool_handle[k], pool_owner[k], TAG_W'($urandom),
                       1'b0, '0);
        end
        repeat (100) random_beat();

        // wait out the last results and a full command time for stray beats
        drain_pending();
        repeat (ENTRIES + 8) @(posedge clk);
        if (error_count == 0)
            $display("tb_keyed_tag_table_rr_evict: done, clean");
        else
            $display("tb_keyed_tag_table_rr_evict: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/ktt_pkg.sv
rtl/ktt_store.sv
rtl/keyed_tag_table_rr_evict.sv
sim/tb_keyed_tag_table_rr_evict.sv
